FILE: sv/dbcd_pkg.sv
// Package for the debounced button chord detector.
// Holds widths, register indexes, reset values, the result record and chord helpers.
// No dependencies.
package dbcd_pkg;

	localparam int BUTTON_COUNT = 3;
	localparam int COUNT_W      = 16;
	localparam int CODE_W       = 3;
	localparam int PHASE_W      = 2;
	localparam int CFG_INDEX_W  = 2;
	localparam int PCOUNT_W     = $clog2(BUTTON_COUNT + 1);

	typedef logic [BUTTON_COUNT-1:0] mask_t;
	typedef logic [COUNT_W-1:0]      count_t;
	typedef logic [CODE_W-1:0]       code_t;
	typedef logic [PCOUNT_W-1:0]     pcount_t;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_COLLECT_TICKS  = CFG_INDEX_W'(1);

	localparam count_t DEBOUNCE_TICKS_RST = COUNT_W'(30);
	localparam count_t COLLECT_TICKS_RST  = COUNT_W'(250);
	localparam count_t COUNT_MAX          = '1;

	// Chord masks and their codes
	localparam mask_t MASK_B1   = 3'b001;
	localparam mask_t MASK_B2   = 3'b010;
	localparam mask_t MASK_B3   = 3'b100;
	localparam mask_t MASK_B1B2 = 3'b011;
	localparam mask_t MASK_B2B3 = 3'b110;

	localparam code_t CODE_B1   = 3'd0;
	localparam code_t CODE_B2   = 3'd1;
	localparam code_t CODE_B3   = 3'd2;
	localparam code_t CODE_B1B2 = 3'd3;
	localparam code_t CODE_B2B3 = 3'd4;
	localparam code_t CODE_NONE = 3'd0;

	// One result item
	typedef struct packed {
		mask_t                     stable_buttons;
		logic                      chord_valid;
		code_t                     chord_code;
		logic [PHASE_W-1:0]        phase_now;
	} result_t;

	// Number of pressed buttons in a mask
	function automatic pcount_t pressed_count(input mask_t m);
		pcount_t n;
		n = '0;
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			n = n + pcount_t'(m[i]);
		end
		return n;
	endfunction

	// Chord lookup: valid bit on top, code below
	function automatic logic [CODE_W:0] chord_of(input mask_t m);
		logic [CODE_W:0] r;
		unique case (m)
			MASK_B1:   r = {1'b1, CODE_B1};
			MASK_B2:   r = {1'b1, CODE_B2};
			MASK_B3:   r = {1'b1, CODE_B3};
			MASK_B1B2: r = {1'b1, CODE_B1B2};
			MASK_B2B3: r = {1'b1, CODE_B2B3};
			default:   r = {1'b0, CODE_NONE};
		endcase
		return r;
	endfunction

endpackage

FILE: sv/debounced_button_chord_detector.sv
// Top level of the debounced button chord detector: debouncer, phase machine and
// a two-entry result buffer (output register plus skid register).
// Depends on dbcd_pkg.

// Each accepted input is one tick carrying the raw 3-button mask; each tick yields
// exactly one result (debounced mask, chord strobe and code, phase). An item is taken
// every cycle while the skid register is free: the whole per-tick update is one pass
// of small logic from the state registers to the result register, so throughput is one
// tick per clock while the buffer has room. A skid register lets one more tick
// be taken while a result is stalled; input ready drops only when both are full.
// Configuration writes take effect at once and are always ready; write only when idle.
module debounced_button_chord_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dbcd_pkg::BUTTON_COUNT-1:0]   raw_buttons,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [dbcd_pkg::BUTTON_COUNT-1:0]   stable_buttons,
	output logic                                chord_valid,
	output logic [dbcd_pkg::CODE_W-1:0]         chord_code,
	output logic [dbcd_pkg::PHASE_W-1:0]        phase_now,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dbcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [dbcd_pkg::COUNT_W-1:0]        cfg_data
);

	typedef enum logic [dbcd_pkg::PHASE_W-1:0] {
		PH_IDLE     = 2'd0,
		PH_COLLECT  = 2'd1,
		PH_COOLDOWN = 2'd2
	} phase_t;

	dbcd_pkg::count_t  debounce_ticks_q;
	dbcd_pkg::count_t  collect_ticks_q;
	dbcd_pkg::mask_t   cand_q;
	dbcd_pkg::count_t  deb_cnt_q;
	dbcd_pkg::mask_t   stable_q;
	phase_t            phase_q;
	dbcd_pkg::count_t  col_cnt_q;
	dbcd_pkg::mask_t   best_q;

	dbcd_pkg::result_t out_q;
	dbcd_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;

	dbcd_pkg::mask_t   cand_n;
	dbcd_pkg::count_t  deb_cnt_n;
	dbcd_pkg::mask_t   stable_n;
	phase_t            phase_n;
	dbcd_pkg::count_t  col_cnt_n;
	dbcd_pkg::mask_t   best_n;
	logic [dbcd_pkg::CODE_W:0] chord_lu;
	dbcd_pkg::result_t res_n;

	logic in_xfer;
	logic out_xfer;

	assign in_ready  = !skid_valid_q;
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid_q && out_ready;

	// Debounce: restart on change, saturate otherwise, then promote the candidate
	always_comb begin
		if (raw_buttons != cand_q) begin
			cand_n    = raw_buttons;
			deb_cnt_n = '0;
		end else begin
			cand_n    = cand_q;
			deb_cnt_n = (deb_cnt_q != dbcd_pkg::COUNT_MAX) ? deb_cnt_q + 1'b1 : deb_cnt_q;
		end
		stable_n = (deb_cnt_n >= debounce_ticks_q) ? cand_n : stable_q;
	end

	// Phase machine and result for this tick
	always_comb begin
		phase_n   = phase_q;
		col_cnt_n = col_cnt_q;
		best_n    = best_q;
		chord_lu  = '0;
		unique case (phase_q)
			PH_COLLECT: begin
				if (stable_n != '0 &&
				    dbcd_pkg::pressed_count(stable_n) > dbcd_pkg::pressed_count(best_q)) begin
					best_n = stable_n;
				end
				if (col_cnt_q != dbcd_pkg::COUNT_MAX) begin
					col_cnt_n = col_cnt_q + 1'b1;
				end
				if (col_cnt_n >= collect_ticks_q) begin
					chord_lu = dbcd_pkg::chord_of(best_n);
					phase_n  = PH_COOLDOWN;
				end
			end
			PH_COOLDOWN: begin
				if (stable_n == '0) begin
					phase_n = PH_IDLE;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				if (stable_n != '0) begin
					phase_n   = PH_COLLECT;
					col_cnt_n = '0;
					best_n    = stable_n;
				end
			end
		endcase
		res_n.stable_buttons = stable_n;
		res_n.chord_valid    = chord_lu[dbcd_pkg::CODE_W];
		res_n.chord_code     = chord_lu[dbcd_pkg::CODE_W-1:0];
		res_n.phase_now      = phase_n;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= dbcd_pkg::DEBOUNCE_TICKS_RST;
			collect_ticks_q  <= dbcd_pkg::COLLECT_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == dbcd_pkg::REG_DEBOUNCE_TICKS) begin
				debounce_ticks_q <= cfg_data;
			end else if (cfg_index == dbcd_pkg::REG_COLLECT_TICKS) begin
				collect_ticks_q <= cfg_data;
			end
		end
	end

	// Advance the tick state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q    <= '0;
			deb_cnt_q <= '0;
			stable_q  <= '0;
			phase_q   <= PH_IDLE;
			col_cnt_q <= '0;
			best_q    <= '0;
		end else if (in_xfer) begin
			cand_q    <= cand_n;
			deb_cnt_q <= deb_cnt_n;
			stable_q  <= stable_n;
			phase_q   <= phase_n;
			col_cnt_q <= col_cnt_n;
			best_q    <= best_n;
		end
	end

	// Result buffer: output register backed by one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_xfer) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_xfer;
			end
		end else if (in_xfer) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payloads
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_xfer) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_xfer) begin
				out_q <= res_n;
			end
		end else if (in_xfer) begin
			skid_q <= res_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign stable_buttons = out_q.stable_buttons;
	assign chord_valid    = out_q.chord_valid;
	assign chord_code     = out_q.chord_code;
	assign phase_now      = out_q.phase_now;

	// A chord is only emitted on the tick that ends collection
	a_chord_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.chord_valid |-> out_q.phase_now == PH_COOLDOWN)
		else $error("chord emitted outside the transition to cooldown");

	// No code without a chord strobe
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.chord_valid |-> out_q.chord_code == dbcd_pkg::CODE_NONE)
		else $error("chord code set without chord strobe");

	// The skid entry fills only behind a held output
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// While collecting the kept mask always has a button
	a_best_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_COLLECT |-> best_q != '0)
		else $error("collecting with empty kept mask");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for debounced_button_chord_detector: a scoreboard class that predicts
// every tick result, plus tasks that drive ticks and register writes.
// Depends on dbcd_pkg and the detector RTL.
module tb;
	import dbcd_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 10;
	localparam int TAIL_CYCLES    = 10;
	localparam int SETTLE_CYCLES  = 2;
	localparam int HOLD_CYCLES    = 300;
	localparam int GESTURE_CAP    = 12;
	localparam int N_PHASES       = 7;
	localparam int STEADY_PHASE   = 3;
	localparam int PRESSURE_PHASE = 5;

	// Indexes past the register list; writes there must change nothing
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = CFG_INDEX_W'(3);

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE     = 2'd0,
		PH_COLLECT  = 2'd1,
		PH_COOLDOWN = 2'd2
	} chord_phase_e;

	// Predicts one result per tick and checks results in order
	class chord_scoreboard;
		count_t       debounce_limit;
		count_t       collect_limit;
		mask_t        candidate;
		count_t       bounce_count;
		mask_t        stable;
		chord_phase_e phase;
		count_t       window_count;
		mask_t        best;
		result_t      tick_results_due[$];
		int           errors;

		function new();
			debounce_limit = DEBOUNCE_TICKS_RST;
			collect_limit  = COLLECT_TICKS_RST;
			candidate      = '0;
			bounce_count   = '0;
			stable         = '0;
			phase          = PH_IDLE;
			window_count   = '0;
			best           = '0;
			errors         = 0;
		endfunction

		function void write_reg(input logic [CFG_INDEX_W-1:0] idx, input count_t value);
			case (idx)
				REG_DEBOUNCE_TICKS: debounce_limit = value;
				REG_COLLECT_TICKS:  collect_limit = value;
				default: ;
			endcase
		endfunction

		function void chord_for(input mask_t m, output logic hit, output code_t code);
			hit = 1'b1;
			case (m)
				MASK_B1:   code = CODE_B1;
				MASK_B2:   code = CODE_B2;
				MASK_B3:   code = CODE_B3;
				MASK_B1B2: code = CODE_B1B2;
				MASK_B2B3: code = CODE_B2B3;
				default: begin
					hit  = 1'b0;
					code = CODE_NONE;
				end
			endcase
		endfunction

		// Advance the debouncer and the phase machine by one accepted tick
		function void note_tick(input mask_t raw);
			result_t want;
			logic    hit;
			code_t   code;
			hit  = 1'b0;
			code = CODE_NONE;
			if (raw != candidate) begin
				candidate    = raw;
				bounce_count = '0;
			end else if (bounce_count != COUNT_MAX) begin
				bounce_count = bounce_count + 1'b1;
			end
			if (bounce_count >= debounce_limit)
				stable = candidate;

			case (phase)
				PH_COLLECT: begin
					if (stable != '0 && $countones(stable) > $countones(best))
						best = stable;
					if (window_count != COUNT_MAX)
						window_count = window_count + 1'b1;
					if (window_count >= collect_limit) begin
						chord_for(best, hit, code);
						phase = PH_COOLDOWN;
					end
				end
				PH_COOLDOWN: begin
					if (stable == '0)
						phase = PH_IDLE;
				end
				default: begin
					phase = PH_IDLE;
					if (stable != '0) begin
						phase        = PH_COLLECT;
						window_count = '0;
						best         = stable;
					end
				end
			endcase

			want.stable_buttons = stable;
			want.chord_valid    = hit;
			want.chord_code     = code;
			want.phase_now      = phase;
			tick_results_due.push_back(want);
		endfunction

		function void compare(input string field, input int unsigned want,
				input int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d",
					$time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(input result_t got);
			result_t want;
			if (tick_results_due.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual mask %0d phase %0d",
					$time, got.stable_buttons, got.phase_now);
				errors++;
				return;
			end
			want = tick_results_due.pop_front();
			compare("stable_buttons", 32'(want.stable_buttons), 32'(got.stable_buttons));
			compare("chord_valid", 32'(want.chord_valid), 32'(got.chord_valid));
			compare("chord_code", 32'(want.chord_code), 32'(got.chord_code));
			compare("phase_now", 32'(want.phase_now), 32'(got.phase_now));
		endfunction

		function int pending();
			return tick_results_due.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	mask_t                  raw_buttons;
	logic                   out_valid;
	logic                   out_ready;
	mask_t                  stable_buttons;
	logic                   chord_valid;
	code_t                  chord_code;
	logic [PHASE_W-1:0]     phase_now;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	count_t                 cfg_data;

	chord_scoreboard sb = new();

	// steady and hold_request are shared with the result sink; the rest is driver state
	bit steady;
	bit hold_request;
	int ticks_sent;
	int cur_debounce;
	int cur_collect;

	// Settings for each random phase, extremes among them
	int debounce_plan [N_PHASES] = '{1, 0, 2, 3, 65535, 0, 4};
	int collect_plan  [N_PHASES] = '{4, 65535, 0, 8, 65535, 2, 6};
	int length_plan   [N_PHASES] = '{120, 40, 120, 110, 40, 120, 60};

	debounced_button_chord_detector uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.raw_buttons    (raw_buttons),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.stable_buttons (stable_buttons),
		.chord_valid    (chord_valid),
		.chord_code     (chord_code),
		.phase_now      (phase_now),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Offer one tick, idling at random first; valid stays high until the transfer
	task automatic send_tick(input mask_t m);
		while (!steady && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		raw_buttons <= m;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_tick(m);
		ticks_sent++;
	endtask

	// Drop valid and wait until every tick result has been taken
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register; valid is left high for a following write
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input count_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	// Load both windows while the block is drained, plus one ignored write
	task automatic retune(input int debounce, input int collect);
		settle();
		write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, count_t'($urandom));
		write_reg(REG_DEBOUNCE_TICKS, count_t'(debounce));
		write_reg(REG_COLLECT_TICKS, count_t'(collect));
		cfg_valid    <= 1'b0;
		cur_debounce = debounce;
		cur_collect  = collect;
	endtask

	// One press-and-release with bounce; sometimes plain chatter instead
	task automatic play_gesture();
		int    dmax;
		int    cmax;
		mask_t first;
		mask_t second;
		dmax  = (cur_debounce > GESTURE_CAP) ? GESTURE_CAP : cur_debounce;
		cmax  = (cur_collect > GESTURE_CAP) ? GESTURE_CAP : cur_collect;
		first = mask_t'($urandom_range(7, 1));
		if ($urandom_range(5) == 0) begin
			repeat ($urandom_range(8, 1)) send_tick(mask_t'($urandom_range(7)));
			return;
		end
		repeat ($urandom_range(3)) send_tick(mask_t'($urandom_range(7)));
		repeat ($urandom_range(dmax + cmax + 3)) send_tick(first);
		// grow or shift the chord mid-window
		if ($urandom_range(2) == 0) begin
			second = first | mask_t'($urandom_range(7));
			if ($urandom_range(3) == 0)
				second = mask_t'($urandom_range(7, 1));
			repeat ($urandom_range(dmax + cmax + 2)) send_tick(second);
		end
		repeat ($urandom_range(2)) send_tick(mask_t'($urandom_range(7)));
		repeat ($urandom_range(dmax + 4)) send_tick('0);
	endtask

	// Take results with random stalls and one long hold-off on request
	initial begin : result_sink
		result_t got;
		int      hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.stable_buttons = stable_buttons;
				got.chord_valid    = chord_valid;
				got.chord_code     = chord_code;
				got.phase_now      = phase_now;
				sb.check_result(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 30);
			end
		end
	end

	initial begin : stimulus
		int p;
		int start;
		bit pressure_done;
		pressure_done = 1'b0;
		steady        = 1'b0;
		hold_request  = 1'b0;
		ticks_sent    = 0;
		cur_debounce  = int'(DEBOUNCE_TICKS_RST);
		cur_collect   = int'(COLLECT_TICKS_RST);
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		raw_buttons <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset windows: hold a chord past the default debounce
		repeat (40) send_tick(MASK_B2B3);

		// Zero windows: every mask, chord or not, then release
		retune(0, 0);
		for (int m = 1; m < 8; m++) begin
			send_tick(mask_t'(m));
			send_tick(mask_t'(m));
			send_tick('0);
			send_tick('0);
		end

		// Random gestures under each setting
		for (p = 0; p < N_PHASES; p++) begin
			retune(debounce_plan[p], collect_plan[p]);
			steady = (p == STEADY_PHASE);
			start  = ticks_sent;
			while (ticks_sent - start < length_plan[p]) begin
				if (p == PRESSURE_PHASE && !pressure_done && ticks_sent - start >= 40) begin
					hold_request  = 1'b1;
					pressure_done = 1'b1;
				end
				play_gesture();
			end
			steady = 1'b0;
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
